// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL that checks itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: condition must never hold");

// trig in one cycle implies resp in the next
`define ASSERT_NEXT(label, clk, rst, trig, resp) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (resp)) \
    else $error("assertion failed: expected response missing");

`endif

// ----- rtl/firdf_pkg.sv -----
// Shared types and constants of the direct-form FIR filter
`timescale 1ns / 1ps
package firdf_pkg;

  localparam int MAX_TAPS_DEF = 16;
  localparam int DATA_W       = 16;
  localparam int PROD_W       = 32;
  localparam int ACC_W        = 40;
  localparam int FRAC_W       = 15;
  localparam int IDX_W        = 4;
  localparam int TAP_CNT_W    = 5;
  localparam int S_TDATA_W    = 24;
  localparam int M_TDATA_W    = 16;

  localparam logic [TAP_CNT_W-1:0] TAP_CNT_RESET = 5'd16;

  localparam logic OP_LOAD_COEF = 1'b0;
  localparam logic OP_FILTER    = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } fir_state_t;

  typedef struct packed {
    logic clear;
    logic issue;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
  } mac_sts_t;

endpackage

// ----- rtl/firdf_tap_mem.sv -----
// Delay-line and coefficient memories with per-entry valid bits
`timescale 1ns / 1ps
module firdf_tap_mem #(
  parameter int MAX_TAPS = firdf_pkg::MAX_TAPS_DEF,
  parameter int AW       = $clog2(MAX_TAPS)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                dl_we,
  input  logic [AW-1:0]                       dl_waddr,
  input  logic                                coef_we,
  input  logic [AW-1:0]                       coef_waddr,
  input  logic signed [firdf_pkg::DATA_W-1:0] wdata,
  input  logic                                rd_en,
  input  logic [AW-1:0]                       dl_raddr,
  input  logic [AW-1:0]                       coef_raddr,
  output logic signed [firdf_pkg::DATA_W-1:0] dl_rdata,
  output logic signed [firdf_pkg::DATA_W-1:0] coef_rdata
);
  import firdf_pkg::*;

  logic [DATA_W-1:0]   dl_mem   [MAX_TAPS];
  logic [DATA_W-1:0]   coef_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0] dl_valid;
  logic [MAX_TAPS-1:0] coef_valid;
  logic [DATA_W-1:0]   dl_q;
  logic [DATA_W-1:0]   coef_q;
  logic                dl_vq;
  logic                coef_vq;

  always_ff @(posedge clk) begin
    if (dl_we) begin
      dl_mem[dl_waddr] <= wdata;
    end
    if (coef_we) begin
      coef_mem[coef_waddr] <= wdata;
    end
    if (rd_en) begin
      dl_q   <= dl_mem[dl_raddr];
      coef_q <= coef_mem[coef_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dl_valid   <= '0;
      coef_valid <= '0;
      dl_vq      <= 1'b0;
      coef_vq    <= 1'b0;
    end else begin
      if (dl_we) begin
        dl_valid[dl_waddr] <= 1'b1;
      end
      if (coef_we) begin
        coef_valid[coef_waddr] <= 1'b1;
      end
      if (rd_en) begin
        dl_vq   <= dl_valid[dl_raddr];
        coef_vq <= coef_valid[coef_raddr];
      end
    end
  end

  assign dl_rdata   = dl_vq ? signed'(dl_q) : '0;
  assign coef_rdata = coef_vq ? signed'(coef_q) : '0;

endmodule

// ----- rtl/firdf_mac.sv -----
// Shared multiply-accumulate with output scaling and saturation
`timescale 1ns / 1ps
module firdf_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  firdf_pkg::mac_ctl_t                 ctl,
  output firdf_pkg::mac_sts_t                 sts,
  input  logic signed [firdf_pkg::DATA_W-1:0] dl_rdata,
  input  logic signed [firdf_pkg::DATA_W-1:0] coef_rdata,
  output logic signed [firdf_pkg::DATA_W-1:0] filtered,
  output logic                                clipped
);
  import firdf_pkg::*;

  localparam int TOP_W = ACC_W - FRAC_W - DATA_W + 1;

  logic                     rd_v;
  logic                     mul_v;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic [TOP_W-1:0]         top_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v  <= 1'b0;
      mul_v <= 1'b0;
    end else begin
      rd_v  <= ctl.issue;
      mul_v <= rd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v) begin
      prod <= dl_rdata * coef_rdata;
    end
    if (ctl.clear) begin
      acc <= '0;
    end else if (mul_v) begin
      acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  assign sts.busy = rd_v | mul_v;

  assign top_bits = acc[ACC_W-1:FRAC_W+DATA_W-1];

  always_comb begin
    clipped  = !((&top_bits) || !(|top_bits));
    filtered = signed'(acc[FRAC_W+DATA_W-1:FRAC_W]);
    if (clipped) begin
      filtered = acc[ACC_W-1] ? signed'({1'b1, {(DATA_W-1){1'b0}}})
                              : signed'({1'b0, {(DATA_W-1){1'b1}}});
    end
  end

endmodule

// ----- rtl/firdf_ctrl.sv -----
// Sequencer: intake, delay-line pointer, tap walk and output register
`timescale 1ns / 1ps
module firdf_ctrl #(
  parameter int MAX_TAPS = firdf_pkg::MAX_TAPS_DEF,
  parameter int AW       = $clog2(MAX_TAPS)
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [firdf_pkg::TAP_CNT_W-1:0]        cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_op,
  input  logic [firdf_pkg::IDX_W-1:0]            in_idx,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [firdf_pkg::DATA_W-1:0]    out_filtered,
  output logic                                   out_clipped,
  output firdf_pkg::mac_ctl_t                    mac_ctl,
  input  firdf_pkg::mac_sts_t                    mac_sts,
  input  logic signed [firdf_pkg::DATA_W-1:0]    mac_filtered,
  input  logic                                   mac_clipped,
  output logic                                   dl_we,
  output logic [AW-1:0]                          dl_waddr,
  output logic                                   coef_we,
  output logic [AW-1:0]                          coef_waddr,
  output logic                                   rd_en,
  output logic [AW-1:0]                          dl_raddr,
  output logic [AW-1:0]                          coef_raddr
);
  import firdf_pkg::*;

  localparam int TW = $clog2(MAX_TAPS + 1);
  localparam int CW = (TW > TAP_CNT_W) ? TW : TAP_CNT_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);
  localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_TAPS);

  fir_state_t           state;
  fir_state_t           state_next;
  logic [TAP_CNT_W-1:0] tap_count;
  logic [AW-1:0]        ptr;
  logic [AW-1:0]        ptr_next;
  logic [AW-1:0]        rd_addr;
  logic [CW-1:0]        issue_cnt;
  logic [CW-1:0]        taps_eff;
  logic                 accept;
  logic                 accept_sample;
  logic                 load_out;

  assign taps_eff = (CW'(tap_count) > MAX_CNT) ? MAX_CNT : CW'(tap_count);
  assign ptr_next = (ptr == '0) ? LAST_ADDR : ptr - AW'(1);
  assign accept        = in_valid && in_ready;
  assign accept_sample = accept && (in_op == OP_FILTER);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept_sample) begin
          state_next = (taps_eff == '0) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue_cnt == taps_eff - CW'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_sts.busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == ST_IDLE);
    mac_ctl.issue = (state == ST_RUN);
    mac_ctl.clear = accept_sample;
    load_out      = (state == ST_DONE) && (!out_valid || out_ready);
    rd_en         = (state == ST_RUN);
    dl_we         = accept_sample;
    dl_waddr      = ptr_next;
    coef_we       = accept && (in_op == OP_LOAD_COEF) && (CW'(in_idx) < MAX_CNT);
    coef_waddr    = AW'(in_idx);
    dl_raddr      = rd_addr;
    coef_raddr    = issue_cnt[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tap_count <= TAP_CNT_RESET;
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        tap_count <= cfg_wdata;
      end
      if (accept_sample) begin
        ptr <= ptr_next;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_sample) begin
      rd_addr   <= ptr_next;
      issue_cnt <= '0;
    end else if (state == ST_RUN) begin
      rd_addr   <= (rd_addr == LAST_ADDR) ? '0 : rd_addr + AW'(1);
      issue_cnt <= issue_cnt + CW'(1);
    end
    if (load_out) begin
      out_filtered <= mac_filtered;
      out_clipped  <= mac_clipped;
    end
  end

endmodule

// ----- rtl/fir_filter_direct_form_core.sv -----
// Top level of the direct-form FIR filter
// Usage:
//   Input stream s_axis: tuser selects the transaction kind. A coefficient
//   transaction writes tdata tap_index/value into the coefficient memory and
//   yields no output. A sample transaction pushes value into the delay line
//   and yields one output transaction on m_axis: filtered in tdata, clipped
//   in tuser.
//   cfg_we/cfg_wdata set the tap count; write it only while the block idles.
//   Samples are handled one at a time: the next transaction is accepted only
//   after the single multiply-accumulate has walked the delay-line and
//   coefficient memories one tap per cycle (read, multiply, accumulate),
//   drained and loaded the output register. A coefficient transaction leaves
//   the sequencer idle, ready for the next transaction.
//   s_axis_tready is high while the sequencer is idle; a result waiting in
//   the output register does not block the next transaction, only the
//   following result is held until m_axis_tready frees the register.
//   Reset: synchronous rst clears both memories through valid bits at once,
//   sets the tap count to 16 and drops any pending output.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fir_filter_direct_form_core #(
  parameter int MAX_TAPS = firdf_pkg::MAX_TAPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [firdf_pkg::TAP_CNT_W-1:0]     cfg_wdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [firdf_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // tap_index[3:0], value[19:4]
  input  logic                                s_axis_tuser,  // operation
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [firdf_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // filtered[15:0]
  output logic                                m_axis_tuser   // clipped
);
  import firdf_pkg::*;

  localparam int AW = $clog2(MAX_TAPS);

  mac_ctl_t                 mac_ctl;
  mac_sts_t                 mac_sts;
  logic signed [DATA_W-1:0] in_value;
  logic signed [DATA_W-1:0] dl_rdata;
  logic signed [DATA_W-1:0] coef_rdata;
  logic signed [DATA_W-1:0] mac_filtered;
  logic                     mac_clipped;
  logic signed [DATA_W-1:0] out_filtered;
  logic                     dl_we;
  logic                     coef_we;
  logic                     rd_en;
  logic [AW-1:0]            dl_waddr;
  logic [AW-1:0]            coef_waddr;
  logic [AW-1:0]            dl_raddr;
  logic [AW-1:0]            coef_raddr;

  assign in_value     = signed'(s_axis_tdata[IDX_W+DATA_W-1:IDX_W]);
  assign m_axis_tdata = out_filtered;

  firdf_ctrl #(
    .MAX_TAPS (MAX_TAPS),
    .AW       (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_op        (s_axis_tuser),
    .in_idx       (s_axis_tdata[IDX_W-1:0]),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_filtered (out_filtered),
    .out_clipped  (m_axis_tuser),
    .mac_ctl      (mac_ctl),
    .mac_sts      (mac_sts),
    .mac_filtered (mac_filtered),
    .mac_clipped  (mac_clipped),
    .dl_we        (dl_we),
    .dl_waddr     (dl_waddr),
    .coef_we      (coef_we),
    .coef_waddr   (coef_waddr),
    .rd_en        (rd_en),
    .dl_raddr     (dl_raddr),
    .coef_raddr   (coef_raddr)
  );

  firdf_tap_mem #(
    .MAX_TAPS (MAX_TAPS),
    .AW       (AW)
  ) u_tap_mem (
    .clk        (clk),
    .rst        (rst),
    .dl_we      (dl_we),
    .dl_waddr   (dl_waddr),
    .coef_we    (coef_we),
    .coef_waddr (coef_waddr),
    .wdata      (in_value),
    .rd_en      (rd_en),
    .dl_raddr   (dl_raddr),
    .coef_raddr (coef_raddr),
    .dl_rdata   (dl_rdata),
    .coef_rdata (coef_rdata)
  );

  firdf_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .ctl        (mac_ctl),
    .sts        (mac_sts),
    .dl_rdata   (dl_rdata),
    .coef_rdata (coef_rdata),
    .filtered   (mac_filtered),
    .clipped    (mac_clipped)
  );

  `ASSERT_NEVER(a_ready_while_busy, clk, rst, s_axis_tready && mac_sts.busy)
  `ASSERT_NEVER(a_issue_while_ready, clk, rst, s_axis_tready && mac_ctl.issue)
  `ASSERT_NEVER(a_write_while_walk, clk, rst, (dl_we || coef_we) && rd_en)
  `ASSERT_NEXT(a_sample_blocks, clk, rst, s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_FILTER), !s_axis_tready)

endmodule
